/* rtl/drp_pkg.sv */
package drp_pkg;

   // Header layout and option codes.
   localparam logic [7:0] HDR_LEN    = 8'd240;
   localparam logic [7:0] OP_REPLY   = 8'd2;
   localparam logic [7:0] OPT_PAD    = 8'd0;
   localparam logic [7:0] OPT_END    = 8'd255;
   localparam logic [7:0] OPT_MASK   = 8'd1;
   localparam logic [7:0] OPT_ROUTER = 8'd3;
   localparam logic [7:0] OPT_LEASE  = 8'd51;
   localparam logic [7:0] OPT_TYPE   = 8'd53;
   localparam logic [7:0] OPT_SERVER = 8'd54;
   localparam logic [7:0] MT_OFFER   = 8'd2;
   localparam logic [7:0] MT_ACK     = 8'd5;
   localparam logic [7:0] MT_NAK     = 8'd6;

   localparam logic [7:0] XID_FIRST    = 8'd4;
   localparam logic [7:0] XID_LAST     = 8'd7;
   localparam logic [7:0] YIADDR_FIRST = 8'd16;
   localparam logic [7:0] YIADDR_LAST  = 8'd19;
   localparam logic [7:0] MAC_FIRST    = 8'd28;
   localparam logic [7:0] MAC_LAST     = 8'd33;
   localparam logic [7:0] COOKIE_FIRST = 8'd236;
   localparam logic [7:0] COOKIE_LAST  = 8'd239;

   localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_XID   = 2'd0;
   localparam logic [1:0] REG_MAC   = 2'd1;
   localparam logic [1:0] REG_PHASE = 2'd2;

   // Client phases.
   localparam logic [1:0] CP_SELECTING  = 2'd0;
   localparam logic [1:0] CP_REQUESTING = 2'd1;
   localparam logic [1:0] CP_RENEWING   = 2'd2;
   localparam logic [1:0] CP_OTHER      = 2'd3;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_NOT_OURS  = 3'd2,
      ST_MALFORMED = 3'd3,
      ST_NO_TYPE   = 3'd4,
      ST_NO_ADV    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PH_CODE = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      DST_NONE   = 3'd0,
      DST_YIADDR = 3'd1,
      DST_TYPE   = 3'd2,
      DST_MASK   = 3'd3,
      DST_ROUTER = 3'd4,
      DST_SERVER = 3'd5,
      DST_LEASE  = 3'd6
   } dest_type;

   typedef struct packed {
      logic [31:0] xid;
      logic [47:0] mac;
      logic [1:0]  phase;
   } cfg_type;

   // One classified byte travelling from the front to the back.
   typedef struct packed {
      logic [7:0] data;
      dest_type   dest;
      logic       last;
      logic       short_pkt;
      logic       not_ours;
      logic       malformed;
   } cmd_type;

   function automatic logic length_bad(input logic [7:0] code, input logic [7:0] len);
      logic bad;
      bad = 1'b0;
      case (code)
         OPT_TYPE:                       bad = (len != 8'd1);
         OPT_MASK, OPT_SERVER, OPT_LEASE: bad = (len != 8'd4);
         OPT_ROUTER:                     bad = (len < 8'd4);
         default:                        bad = 1'b0;
      endcase
      return bad;
   endfunction

   function automatic dest_type body_dest(input logic [7:0] code, input logic [7:0] cnt);
      dest_type d;
      d = DST_NONE;
      case (code)
         OPT_TYPE:   d = DST_TYPE;
         OPT_MASK:   d = DST_MASK;
         OPT_SERVER: d = DST_SERVER;
         OPT_LEASE:  d = DST_LEASE;
         OPT_ROUTER: d = (cnt < 8'd4) ? DST_ROUTER : DST_NONE;
         default:    d = DST_NONE;
      endcase
      return d;
   endfunction

   // Byte sel of a 32-bit word, sel 3 being the most significant.
   function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd0:    b = w[7:0];
         2'd1:    b = w[15:8];
         2'd2:    b = w[23:16];
         default: b = w[31:24];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [2:0] sel);
      logic [7:0] b;
      case (sel)
         3'd0:    b = m[7:0];
         3'd1:    b = m[15:8];
         3'd2:    b = m[23:16];
         3'd3:    b = m[31:24];
         3'd4:    b = m[39:32];
         3'd5:    b = m[47:40];
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

/* rtl/drp_if.sv */
interface drp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drp_rsp_if;
   import drp_pkg::*;
   logic        valid;
   logic        ready;
   logic        accepted;
   status_type  status;
   logic [7:0]  message_type;
   logic [31:0] offered_address;
   logic [31:0] subnet_mask;
   logic [31:0] router_address;
   logic [31:0] server_address;
   logic [31:0] lease_seconds;

   modport source (output valid, output accepted, output status, output message_type,
                   output offered_address, output subnet_mask, output router_address,
                   output server_address, output lease_seconds, input ready);
   modport sink   (input valid, input accepted, input status, input message_type,
                   input offered_address, input subnet_mask, input router_address,
                   input server_address, input lease_seconds, output ready);
endinterface

interface drp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* rtl/drp_front.sv */
module drp_front (
   input  logic             clock,
   input  logic             reset,
   drp_req_if.sink          req,
   input  drp_pkg::cfg_type cfg,
   input  logic             q_ready,
   output logic             q_push,
   output drp_pkg::cmd_type q_cmd
);
   import drp_pkg::*;

   logic [7:0] hdr_cnt_ff, hdr_cnt_in;
   logic       hdr_ok_ff, hdr_ok_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] body_cnt_ff, body_cnt_in;
   logic       malformed_ff, malformed_in;
   logic [7:0] idx;
   logic [2:0] mac_sel;
   logic [7:0] b;

   assign req.ready = q_ready;
   assign q_push    = req.valid && q_ready;
   assign idx       = hdr_cnt_ff;
   assign mac_sel   = 3'(MAC_LAST - idx);
   assign b         = req.data_byte;

   always_comb begin
      hdr_cnt_in   = hdr_cnt_ff;
      hdr_ok_in    = hdr_ok_ff;
      phase_in     = phase_ff;
      code_in      = code_ff;
      len_in       = len_ff;
      body_cnt_in  = body_cnt_ff;
      malformed_in = malformed_ff;
      q_cmd.data   = b;
      q_cmd.dest   = DST_NONE;
      q_cmd.last   = req.last_byte;

      if (hdr_cnt_ff < HDR_LEN) begin
         hdr_cnt_in = hdr_cnt_ff + 8'd1;
         if (idx == 8'd0) begin
            if (b != OP_REPLY) hdr_ok_in = 1'b0;
         end else if (idx >= XID_FIRST && idx <= XID_LAST) begin
            if (b != word_byte(cfg.xid, ~idx[1:0])) hdr_ok_in = 1'b0;
         end else if (idx >= YIADDR_FIRST && idx <= YIADDR_LAST) begin
            q_cmd.dest = DST_YIADDR;
         end else if (idx >= MAC_FIRST && idx <= MAC_LAST) begin
            if (b != mac_byte(cfg.mac, mac_sel)) hdr_ok_in = 1'b0;
         end else if (idx >= COOKIE_FIRST && idx <= COOKIE_LAST) begin
            if (b != COOKIE[idx[1:0]]) hdr_ok_in = 1'b0;
         end
      end else begin
         unique case (phase_ff)
            PH_CODE: begin
               if (b == OPT_END) begin
                  phase_in = PH_DONE;
               end else if (b != OPT_PAD) begin
                  code_in  = b;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               len_in = b;
               if (length_bad(code_ff, b)) begin
                  malformed_in = 1'b1;
                  phase_in     = PH_DONE;
               end else if (b == 8'd0) begin
                  phase_in = PH_CODE;
               end else begin
                  body_cnt_in = 8'd0;
                  phase_in    = PH_BODY;
               end
            end
            PH_BODY: begin
               q_cmd.dest  = body_dest(code_ff, body_cnt_ff);
               body_cnt_in = body_cnt_ff + 8'd1;
               if (body_cnt_in == len_ff) phase_in = PH_CODE;
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      q_cmd.short_pkt = (hdr_cnt_in < HDR_LEN);
      q_cmd.not_ours  = !hdr_ok_in;
      q_cmd.malformed = malformed_in || (phase_in != PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset || (q_push && req.last_byte)) begin
         hdr_cnt_ff   <= 8'd0;
         hdr_ok_ff    <= 1'b1;
         phase_ff     <= PH_CODE;
         code_ff      <= 8'd0;
         len_ff       <= 8'd0;
         body_cnt_ff  <= 8'd0;
         malformed_ff <= 1'b0;
      end else if (q_push) begin
         hdr_cnt_ff   <= hdr_cnt_in;
         hdr_ok_ff    <= hdr_ok_in;
         phase_ff     <= phase_in;
         code_ff      <= code_in;
         len_ff       <= len_in;
         body_cnt_ff  <= body_cnt_in;
         malformed_ff <= malformed_in;
      end
   end

endmodule

/* rtl/drp_queue.sv */
module drp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  drp_pkg::cmd_type push_cmd,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output drp_pkg::cmd_type pop_cmd
);
   import drp_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* rtl/drp_back.sv */
module drp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  drp_pkg::cmd_type q_cmd,
   output logic             q_pop,
   input  drp_pkg::cfg_type cfg,
   drp_rsp_if.source        rsp
);
   import drp_pkg::*;

   logic [7:0]  type_ff, type_in;
   logic [31:0] yiaddr_ff, yiaddr_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] server_ff, server_in;
   logic [31:0] lease_ff, lease_in;

   logic        out_valid_ff;
   logic        accepted_ff, accepted_in;
   status_type  status_ff, status_in;
   logic [7:0]  mtype_ff;
   logic [31:0] offered_ff, subnet_ff, routerq_ff, serverq_ff, leaseq_ff;
   logic        adv;
   logic        data_valid;
   logic        out_free;
   logic        finish;

   // The output register frees itself in the same cycle that the sink takes it.
   assign out_free = !out_valid_ff || rsp.ready;
   assign q_pop    = q_valid && (!q_cmd.last || out_free);
   assign finish   = q_pop && q_cmd.last;

   always_comb begin
      type_in   = type_ff;
      yiaddr_in = yiaddr_ff;
      mask_in   = mask_ff;
      router_in = router_ff;
      server_in = server_ff;
      lease_in  = lease_ff;
      case (q_cmd.dest)
         DST_YIADDR: yiaddr_in = {yiaddr_ff[23:0], q_cmd.data};
         DST_TYPE:   type_in   = q_cmd.data;
         DST_MASK:   mask_in   = {mask_ff[23:0], q_cmd.data};
         DST_ROUTER: router_in = {router_ff[23:0], q_cmd.data};
         DST_SERVER: server_in = {server_ff[23:0], q_cmd.data};
         DST_LEASE:  lease_in  = {lease_ff[23:0], q_cmd.data};
         default: begin
         end
      endcase

      adv = 1'b0;
      if (cfg.phase == CP_SELECTING) begin
         adv = (type_in == MT_OFFER) && (server_in != 32'd0);
      end else if (cfg.phase == CP_REQUESTING || cfg.phase == CP_RENEWING) begin
         adv = (type_in == MT_ACK) || (type_in == MT_NAK);
      end

      if (q_cmd.short_pkt)      status_in = ST_SHORT;
      else if (q_cmd.not_ours)  status_in = ST_NOT_OURS;
      else if (q_cmd.malformed) status_in = ST_MALFORMED;
      else if (type_in == 8'd0) status_in = ST_NO_TYPE;
      else if (adv)             status_in = ST_OK;
      else                      status_in = ST_NO_ADV;

      accepted_in = (status_in == ST_OK);
      data_valid  = (status_in == ST_OK) || (status_in == ST_NO_TYPE) ||
                    (status_in == ST_NO_ADV);
   end

   // Per-packet capture stores; cleared when the last byte is retired.
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         type_ff   <= 8'd0;
         yiaddr_ff <= 32'd0;
         mask_ff   <= 32'd0;
         router_ff <= 32'd0;
         server_ff <= 32'd0;
         lease_ff  <= 32'd0;
      end else if (q_pop) begin
         type_ff   <= type_in;
         yiaddr_ff <= yiaddr_in;
         mask_ff   <= mask_in;
         router_ff <= router_in;
         server_ff <= server_in;
         lease_ff  <= lease_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         accepted_ff <= accepted_in;
         status_ff   <= status_in;
         mtype_ff    <= data_valid ? type_in : 8'd0;
         offered_ff  <= data_valid ? yiaddr_in : 32'd0;
         subnet_ff   <= data_valid ? mask_in : 32'd0;
         routerq_ff  <= data_valid ? router_in : 32'd0;
         serverq_ff  <= data_valid ? server_in : 32'd0;
         leaseq_ff   <= data_valid ? lease_in : 32'd0;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.accepted        = accepted_ff;
   assign rsp.status          = status_ff;
   assign rsp.message_type    = mtype_ff;
   assign rsp.offered_address = offered_ff;
   assign rsp.subnet_mask     = subnet_ff;
   assign rsp.router_address  = routerq_ff;
   assign rsp.server_address  = serverq_ff;
   assign rsp.lease_seconds   = leaseq_ff;

endmodule

/* rtl/dhcp_reply_parser.sv */
// DHCP reply parser: takes one UDP payload byte per cycle while the queue has room.
// Each byte is classified into the two-entry queue; the result is formed from the last
// byte into the output register once that register is free.
// A waiting result holds back only the next last byte; the input stalls once the queue fills.
// Reset is synchronous and active high: it clears parsing state, the queue and the
// output valid, and loads the transaction id and MAC with 0 and the client phase with 3.
module dhcp_reply_parser (
   input  logic clock,
   input  logic reset,
   drp_req_if.sink   req,
   drp_rsp_if.source rsp,
   drp_csr_if.sink   csr
);
   import drp_pkg::*;

   // Configuration registers. The user must write them only while no packet is in flight
   // (the block does not enforce it); front and back then see one setting per packet.
   logic [31:0] xid_ff;
   logic [47:0] mac_ff;
   logic [1:0]  phase_ff;
   cfg_type     cfg;

   // Front to back hand-off through a short queue, so that a stalled response side
   // does not hold up classification of the bytes that are still arriving.
   logic    q_push;
   logic    q_not_full;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         xid_ff   <= 32'd0;
         mac_ff   <= 48'd0;
         phase_ff <= CP_OTHER;
      end else if (csr.valid) begin
         case (csr.index)
            REG_XID:   xid_ff   <= csr.wdata[31:0];
            REG_MAC:   mac_ff   <= csr.wdata;
            REG_PHASE: phase_ff <= csr.wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.xid   = xid_ff;
   assign cfg.mac   = mac_ff;
   assign cfg.phase = phase_ff;

   // The front checks the fixed header, walks the option TLVs and tags each byte with
   // the store it belongs to. On the last byte it also carries the packet verdict flags.
   drp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .cfg     (cfg),
      .q_ready (q_not_full),
      .q_push  (q_push),
      .q_cmd   (push_cmd)
   );

   drp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (pop_cmd)
   );

   // The back captures the option values and, on the last byte, forms the status and
   // the phase decision into the output register.
   drp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_cmd   (pop_cmd),
      .q_pop   (q_pop),
      .cfg     (cfg),
      .rsp     (rsp)
   );

endmodule
